// File: rtl/core/nearest_center_l1_assign_unit_assert.svh
// Assertion macros for the nearest-centre L1 assignment unit checker.
// Needs signals named clk and rst in the scope of use.
`ifndef NEAREST_CENTER_L1_ASSIGN_UNIT_ASSERT_SVH
`define NEAREST_CENTER_L1_ASSIGN_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nca_pkg.sv
// Shared types, widths and codes of the nearest-centre L1 assignment unit.
// No dependencies.
package nca_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_DIMS_DEF     = 256;

  localparam int RANK_W = 12;
  localparam int DIST_W = 20;
  localparam int SUM_W  = 40;
  localparam int SQ_W   = 60;
  localparam int CNT_W  = 20;
  localparam int PROD_W = 40;
  localparam int IDX_W  = 8;
  localparam int CL_W   = 4;
  localparam int POS_W  = 8;
  localparam int NCL_W  = 5;
  localparam int NDIM_W = 9;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [SQ_W-1:0]   SQ_MAX   = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  localparam logic REG_CLUSTERS = 1'b0;
  localparam logic REG_DIMS     = 1'b1;

  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_STATS  = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POINT = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INJECT,
    ST_CHAIN,
    ST_SQUARE,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Token travelling down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rv;
    logic              in_range;
    logic              last;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_d;
  } tok_t;

  // Statistics command broadcast to every cell.
  typedef struct packed {
    logic              upd;
    logic              clr;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_add;
    logic [PROD_W-1:0] sq;
  } stat_cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sq;
    logic [CNT_W-1:0] cnt;
  } stat_t;

endpackage

// File: rtl/core/nca_item_if.sv
// Input item channel of the nearest-centre L1 assignment unit.
// Depends on nca_pkg.
interface nca_item_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [nca_pkg::CL_W-1:0]   cluster;
  logic [nca_pkg::POS_W-1:0]  position;
  logic [nca_pkg::RANK_W-1:0] rank_value;
  logic                      last_element;

  modport source (output valid, action, cluster, position, rank_value, last_element,
                  input ready);
  modport sink (input valid, action, cluster, position, rank_value, last_element,
                output ready);
endinterface

// File: rtl/core/nca_result_if.sv
// Result channel of the nearest-centre L1 assignment unit.
// Depends on nca_pkg.
interface nca_result_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [nca_pkg::CL_W-1:0]   assigned_cluster;
  logic [nca_pkg::DIST_W-1:0] distance;
  logic [nca_pkg::SUM_W-1:0]  distance_sum;
  logic [nca_pkg::SQ_W-1:0]   distance_square_sum;
  logic [nca_pkg::CNT_W-1:0]  member_count;

  modport source (output valid, kind, assigned_cluster, distance, distance_sum,
                  distance_square_sum, member_count, input ready);
  modport sink (input valid, kind, assigned_cluster, distance, distance_sum,
                distance_square_sum, member_count, output ready);
endinterface

// File: rtl/core/nearest_center_l1_assign_unit.sv
// Nearest-centre L1 assignment unit: top level with a chain of MAX_CLUSTERS cells.
// Load and clear give no result and leave the unit idle; a statistics read passes through
// the emit state and its result is registered at the output. A point element holds the
// unit while its token walks the chain one cell per cycle; a last element then adds the
// square, update and emit states, and emit waits while the result sink stalls.
// Reset restores the register defaults and clears running distances and statistics;
// the centre store is not cleared and holds garbage until loaded.
module nearest_center_l1_assign_unit #(
  parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
  parameter int MAX_DIMS     = nca_pkg::MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  nca_item_if.sink    items,
  nca_result_if.source results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  // Configuration registers
  logic [nca_pkg::NCL_W-1:0]  clusters_in_use;
  logic [nca_pkg::NDIM_W-1:0] dims_in_use;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == nca_pkg::REG_DIMS) ? 32'(dims_in_use) : 32'(clusters_in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= nca_pkg::NCL_W'(16);
      dims_in_use     <= nca_pkg::NDIM_W'(256);
    end else if (cfg_wr) begin
      if (paddr[2] == nca_pkg::REG_CLUSTERS) begin
        clusters_in_use <= pwdata[nca_pkg::NCL_W-1:0];
      end else begin
        dims_in_use <= pwdata[nca_pkg::NDIM_W-1:0];
      end
    end
  end

  // Clamp the registers to their usable ranges
  int n_cl;
  int n_dim;
  always_comb begin
    n_cl  = (clusters_in_use == '0) ? 1 :
            (int'(clusters_in_use) > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(clusters_in_use);
    n_dim = (dims_in_use == '0) ? 1 :
            (int'(dims_in_use) > MAX_DIMS) ? MAX_DIMS : int'(dims_in_use);
  end

  // Control
  nca_pkg::state_t            state;
  nca_pkg::state_t            state_next;
  logic                      accept;
  nca_pkg::action_t          act;
  logic                      emit_go;
  logic [nca_pkg::RANK_W-1:0] p_rv;
  logic                      p_last;
  logic                      p_in_range;
  logic                      r_kind;
  logic [nca_pkg::IDX_W-1:0]  r_idx;
  logic [nca_pkg::DIST_W-1:0] r_dist;
  logic [nca_pkg::PROD_W-1:0] r_sq;
  logic [nca_pkg::CL_W-1:0]   r_cl;

  nca_pkg::tok_t             tok [MAX_CLUSTERS+1];
  nca_pkg::stat_t            cell_stats [MAX_CLUSTERS];
  nca_pkg::stat_cmd_t        cmd;
  nca_pkg::stat_t            sel_stats;

  assign act     = nca_pkg::action_t'(items.action);
  assign accept  = items.valid && items.ready;
  assign emit_go = (state == nca_pkg::ST_EMIT) && (!results.valid || results.ready);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      nca_pkg::ST_IDLE: begin
        if (accept && (act == nca_pkg::ACT_POINT)) begin
          state_next = nca_pkg::ST_INJECT;
        end else if (accept && (act == nca_pkg::ACT_READ)) begin
          state_next = nca_pkg::ST_EMIT;
        end
      end
      nca_pkg::ST_INJECT: state_next = nca_pkg::ST_CHAIN;
      nca_pkg::ST_CHAIN: begin
        if (tok[MAX_CLUSTERS].valid) begin
          state_next = tok[MAX_CLUSTERS].last ? nca_pkg::ST_SQUARE : nca_pkg::ST_IDLE;
        end
      end
      nca_pkg::ST_SQUARE: state_next = nca_pkg::ST_UPDATE;
      nca_pkg::ST_UPDATE: state_next = nca_pkg::ST_EMIT;
      nca_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_next = nca_pkg::ST_IDLE;
        end
      end
      default: state_next = nca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Inject the captured element at the head of the chain
  assign tok[0] = '{valid: (state == nca_pkg::ST_INJECT), rv: p_rv, in_range: p_in_range,
                    last: p_last, best_idx: '0, best_d: '0};

  // Outputs of the sequencer
  always_comb begin
    items.ready  = (state == nca_pkg::ST_IDLE);
    cmd.upd      = (state == nca_pkg::ST_UPDATE);
    cmd.clr      = accept && (act == nca_pkg::ACT_CLEAR);
    cmd.idx      = r_idx;
    cmd.dist_add = r_dist;
    cmd.sq       = r_sq;
  end

  // Capture the item, then the chain's verdict
  always_ff @(posedge clk) begin
    if (accept) begin
      p_rv       <= items.rank_value;
      p_last     <= items.last_element;
      p_in_range <= int'(items.position) < n_dim;
      r_cl       <= items.cluster;
      r_kind     <= (act == nca_pkg::ACT_READ) ? nca_pkg::KIND_STATS : nca_pkg::KIND_ASSIGN;
    end
    if ((state == nca_pkg::ST_CHAIN) && tok[MAX_CLUSTERS].valid) begin
      r_idx  <= tok[MAX_CLUSTERS].best_idx;
      r_dist <= tok[MAX_CLUSTERS].best_d;
    end
    if (state == nca_pkg::ST_SQUARE) begin
      r_sq <= nca_pkg::PROD_W'(r_dist) * nca_pkg::PROD_W'(r_dist);
    end
  end

  // Chain of centre cells
  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    logic wr_en;
    assign wr_en = accept && (act == nca_pkg::ACT_LOAD) && (int'(items.cluster) == k) &&
                   (int'(items.position) < MAX_DIMS);
    nca_cell #(
      .MAX_DIMS (MAX_DIMS),
      .AW       (AW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_addr  (AW'(items.position)),
      .wr_data  (items.rank_value),
      .rd_en    (accept && (act == nca_pkg::ACT_POINT)),
      .rd_addr  (AW'(items.position)),
      .active   (k < n_cl),
      .cell_idx (nca_pkg::IDX_W'(k)),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1]),
      .cmd      (cmd),
      .stats    (cell_stats[k])
    );
  end

  // Select the statistics of the cluster being read; zero beyond the chain
  always_comb begin
    sel_stats = '0;
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      if (int'(r_cl) == k) begin
        sel_stats = cell_stats[k];
      end
    end
  end

  // Output register: hold until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (emit_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      results.kind <= r_kind;
      if (r_kind == nca_pkg::KIND_STATS) begin
        results.assigned_cluster    <= r_cl;
        results.distance            <= '0;
        results.distance_sum        <= sel_stats.sum;
        results.distance_square_sum <= sel_stats.sq;
        results.member_count        <= sel_stats.cnt;
      end else begin
        results.assigned_cluster    <= r_idx[nca_pkg::CL_W-1:0];
        results.distance            <= r_dist;
        results.distance_sum        <= '0;
        results.distance_square_sum <= '0;
        results.member_count        <= '0;
      end
    end
  end

endmodule

// File: rtl/core/nca_cell.sv
// One cell of the centre chain: centre vector memory, running distance,
// running minimum hand-on and cluster statistics. Depends on nca_pkg.
module nca_cell #(
  parameter int MAX_DIMS = nca_pkg::MAX_DIMS_DEF,
  parameter int AW       = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [nca_pkg::RANK_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  logic                      active,
  input  logic [nca_pkg::IDX_W-1:0]  cell_idx,
  input  nca_pkg::tok_t             tok_in,
  output nca_pkg::tok_t             tok_out,
  input  nca_pkg::stat_cmd_t        cmd,
  output nca_pkg::stat_t            stats
);

  logic [nca_pkg::RANK_W-1:0] mem [MAX_DIMS];
  logic [nca_pkg::RANK_W-1:0] rdata;
  logic [nca_pkg::DIST_W-1:0] rd;
  logic [nca_pkg::DIST_W-1:0] rd_add;
  logic [nca_pkg::DIST_W-1:0] rd_next;
  logic [nca_pkg::RANK_W-1:0] diff;
  logic [nca_pkg::DIST_W:0]   acc;
  logic                      take;
  nca_pkg::tok_t             tok_next;
  logic [nca_pkg::SUM_W:0]    sum_acc;
  logic [nca_pkg::SQ_W:0]     sq_acc;
  logic [nca_pkg::CNT_W:0]    cnt_acc;
  logic                      hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    diff   = (tok_in.rv >= rdata) ? tok_in.rv - rdata : rdata - tok_in.rv;
    acc    = {1'b0, rd} + (nca_pkg::DIST_W + 1)'(diff);
    rd_add = (acc >= (nca_pkg::DIST_W + 1)'(nca_pkg::DIST_MAX)) ? nca_pkg::DIST_MAX
                                                             : acc[nca_pkg::DIST_W-1:0];
    rd_next = (active && tok_in.in_range) ? rd_add : rd;
    // earliest index wins ties: only a strictly smaller distance takes over
    take = active && ((cell_idx == '0) || (rd_next < tok_in.best_d));
    tok_next = tok_in;
    if (tok_in.last && take) begin
      tok_next.best_idx = cell_idx;
      tok_next.best_d   = rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd            <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        rd <= tok_in.last ? '0 : rd_next;
      end
    end
    tok_out.rv       <= tok_next.rv;
    tok_out.in_range <= tok_next.in_range;
    tok_out.last     <= tok_next.last;
    tok_out.best_idx <= tok_next.best_idx;
    tok_out.best_d   <= tok_next.best_d;
  end

  always_comb begin
    hit     = cmd.upd && (cmd.idx == cell_idx);
    sum_acc = {1'b0, stats.sum} + (nca_pkg::SUM_W + 1)'(cmd.dist_add);
    sq_acc  = {1'b0, stats.sq} + (nca_pkg::SQ_W + 1)'(cmd.sq);
    cnt_acc = {1'b0, stats.cnt} + (nca_pkg::CNT_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      stats <= '0;
    end else if (hit) begin
      stats.sum <= (sum_acc >= (nca_pkg::SUM_W + 1)'(nca_pkg::SUM_MAX)) ? nca_pkg::SUM_MAX
                                                                   : sum_acc[nca_pkg::SUM_W-1:0];
      stats.sq  <= (sq_acc >= (nca_pkg::SQ_W + 1)'(nca_pkg::SQ_MAX)) ? nca_pkg::SQ_MAX
                                                                : sq_acc[nca_pkg::SQ_W-1:0];
      stats.cnt <= (cnt_acc >= (nca_pkg::CNT_W + 1)'(nca_pkg::CNT_MAX)) ? nca_pkg::CNT_MAX
                                                                   : cnt_acc[nca_pkg::CNT_W-1:0];
    end
  end

endmodule

// File: rtl/core/nca_checker.sv
// Port-level checker for the nearest-centre L1 assignment unit, bound to the top.
// Depends on nca_pkg and the assertion macro header.
`include "nearest_center_l1_assign_unit_assert.svh"

module nca_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      items_valid,
  input logic                      items_ready,
  input logic [1:0]                items_action,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      res_kind,
  input logic [nca_pkg::DIST_W-1:0] res_distance,
  input logic [nca_pkg::SUM_W-1:0]  res_sum,
  input logic [nca_pkg::SQ_W-1:0]   res_sq,
  input logic [nca_pkg::CNT_W-1:0]  res_cnt
);

  `NCA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_distance), "stalled result dropped or changed")
  `NCA_ASSERT_NOW(a_assign_clean, res_valid && (res_kind == nca_pkg::KIND_ASSIGN), (res_sum == '0) && (res_sq == '0) && (res_cnt == '0), "assignment carries statistics")
  `NCA_ASSERT_NOW(a_stats_clean, res_valid && (res_kind == nca_pkg::KIND_STATS), res_distance == '0, "statistics carry a distance")
  `NCA_ASSERT_NEXT(a_load_silent, items_valid && items_ready && (items_action == nca_pkg::ACT_LOAD) && !res_valid, !res_valid, "load produced a result")

endmodule

bind nearest_center_l1_assign_unit nca_checker u_nca_checker (
  .clk          (clk),
  .rst          (rst),
  .items_valid  (items.valid),
  .items_ready  (items.ready),
  .items_action (items.action),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .res_kind     (results.kind),
  .res_distance (results.distance),
  .res_sum      (results.distance_sum),
  .res_sq       (results.distance_square_sum),
  .res_cnt      (results.member_count)
);

// File: test/nearest_center_l1_assign_unit_tb.sv
// Self-checking testbench of the nearest-centre L1 assignment unit.
// Depends on nca_pkg, nca_item_if, nca_result_if and the unit itself.
module nearest_center_l1_assign_unit_tb;
  import nca_pkg::*;

  localparam int N_CL          = MAX_CLUSTERS_DEF;
  localparam int N_DIM         = MAX_DIMS_DEF;
  // Margin for the drain, long enough for the longest point element to finish.
  localparam int DRAIN_CYCLES  = 40;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int PHASE_ITEMS   = 105;

  typedef struct {
    action_t           act;
    logic [CL_W-1:0]   cl;
    logic [POS_W-1:0]  pos;
    logic [RANK_W-1:0] rv;
    logic              last;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [CL_W-1:0]   cl;
    logic [DIST_W-1:0] dist_val;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
    logic [CNT_W-1:0]  cnt;
  } outcome_t;

  // Scoreboard: own copy of the unit state, and the queue of outcomes still due.
  class assign_scoreboard;
    logic [NCL_W-1:0]  clusters_reg;
    logic [NDIM_W-1:0] dims_reg;
    logic [RANK_W-1:0] centres [N_CL][N_DIM];
    bit                loaded  [N_CL][N_DIM];
    logic [63:0]       run_dist [N_CL];
    logic [63:0]       dsum [N_CL];
    logic [63:0]       sqsum [N_CL];
    logic [63:0]       members [N_CL];
    outcome_t          due_q [$];
    int                mismatches;

    function void clear_state();
      clusters_reg = 5'd16;
      dims_reg     = 9'd256;
      mismatches   = 0;
      for (int j = 0; j < N_CL; j++) begin
        run_dist[j] = 0; dsum[j] = 0; sqsum[j] = 0; members[j] = 0;
        for (int p = 0; p < N_DIM; p++) loaded[j][p] = 0;
      end
    endfunction

    function int n_active();
      if (clusters_reg < 1) return 1;
      if (clusters_reg > N_CL) return N_CL;
      return clusters_reg;
    endfunction

    function int n_dims();
      if (dims_reg < 1) return 1;
      if (dims_reg > N_DIM) return N_DIM;
      return dims_reg;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
      if (a >= lim || b >= lim - a) return lim;
      return a + b;
    endfunction

    // True when a point element at pos reads only loaded centre elements.
    function bit column_ready(logic [POS_W-1:0] pos);
      if (pos >= n_dims()) return 1;
      for (int j = 0; j < n_active(); j++)
        if (!loaded[j][pos]) return 0;
      return 1;
    endfunction

    function void note_item(item_t it);
      outcome_t o;
      int best;
      logic [63:0] bestd, diff;
      o = '0;
      case (it.act)
        ACT_LOAD: begin
          centres[it.cl][it.pos] = it.rv;
          loaded[it.cl][it.pos]  = 1;
        end
        ACT_CLEAR: begin
          for (int j = 0; j < N_CL; j++) begin
            dsum[j] = 0; sqsum[j] = 0; members[j] = 0;
          end
        end
        ACT_READ: begin
          o.kind = KIND_STATS;
          o.cl   = it.cl;
          o.sum  = dsum[it.cl][SUM_W-1:0];
          o.sq   = sqsum[it.cl][SQ_W-1:0];
          o.cnt  = members[it.cl][CNT_W-1:0];
          due_q.insert(due_q.size(), o);
        end
        default: begin
          if (it.pos < n_dims())
            for (int j = 0; j < n_active(); j++) begin
              diff = (it.rv >= centres[j][it.pos]) ? it.rv - centres[j][it.pos]
                                                   : centres[j][it.pos] - it.rv;
              run_dist[j] = sat_add(run_dist[j], diff, DIST_MAX);
            end
          if (it.last) begin
            best  = 0;
            bestd = run_dist[0];
            for (int j = 1; j < n_active(); j++)
              if (run_dist[j] < bestd) begin
                bestd = run_dist[j];
                best  = j;
              end
            dsum[best]    = sat_add(dsum[best], bestd, SUM_MAX);
            sqsum[best]   = sat_add(sqsum[best], bestd * bestd, SQ_MAX);
            members[best] = sat_add(members[best], 1, CNT_MAX);
            for (int j = 0; j < N_CL; j++) run_dist[j] = 0;
            o.kind     = KIND_ASSIGN;
            o.cl       = best[CL_W-1:0];
            o.dist_val = bestd[DIST_W-1:0];
            due_q.insert(due_q.size(), o);
          end
        end
      endcase
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d cluster %0d dist %0d", got.kind, got.cl,
                   got.dist_val);
        return;
      end
      want = due_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected k%0d c%0d d%0d s%0d q%0d n%0d, ",
                    "got k%0d c%0d d%0d s%0d q%0d n%0d"},
                   want.kind, want.cl, want.dist_val, want.sum, want.sq, want.cnt,
                   got.kind, got.cl, got.dist_val, got.sum, got.sq, got.cnt);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nca_item_if   items_if ();
  nca_result_if results_if ();

  nearest_center_l1_assign_unit uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  assign_scoreboard sb;
  bit idling_on;
  int stall_left;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: hold ready low for random bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      results_if.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  // Sample both channels at the rising edge; check results before noting new items.
  always @(posedge clk) begin
    if (!rst) begin
      if (results_if.valid && results_if.ready)
        sb.check_outcome({results_if.kind, results_if.assigned_cluster, results_if.distance,
                          results_if.distance_sum, results_if.distance_square_sum,
                          results_if.member_count});
      if (items_if.valid && items_if.ready)
        sb.note_item('{action_t'(items_if.action), items_if.cluster, items_if.position,
                       items_if.rank_value, items_if.last_element});
    end
  end

  // Watchdog: count cycles in which no transaction moves on any port.
  always @(posedge clk) begin
    if (rst || (items_if.valid && items_if.ready) || (results_if.valid && results_if.ready)
        || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Write one register: setup cycle, then access cycle held until pready.
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_CLUSTERS) sb.clusters_reg = value[NCL_W-1:0];
    else                         sb.dims_reg     = value[NDIM_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Present one item and hold it until the unit takes it.
  task automatic send_item(input item_t it);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      items_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    items_if.valid        <= 1'b1;
    items_if.action       <= it.act;
    items_if.cluster      <= it.cl;
    items_if.position     <= it.pos;
    items_if.rank_value   <= it.rv;
    items_if.last_element <= it.last;
    do @(posedge clk); while (!items_if.ready);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    items_if.valid <= 1'b0;
  endtask

  task automatic send(input action_t act, input int cl, input int pos, input int rv,
                      input bit last);
    send_item('{act, cl[CL_W-1:0], pos[POS_W-1:0], rv[RANK_W-1:0], last});
  endtask

  // Wait for every due result, then let a late point finish before registers change.
  task automatic drain();
    drop_valid();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Pick a point position whose centre elements are all loaded.
  function automatic logic [POS_W-1:0] safe_pos(input logic [POS_W-1:0] pos);
    if (sb.column_ready(pos)) return pos;
    return POS_W'($urandom_range(0, 7));
  endfunction

  // Random flag for the last mark of noise items.
  function automatic bit coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  // Well-formed point: a run of elements ending with the last mark.
  task automatic send_point();
    int len;
    logic [POS_W-1:0] p;
    len = (sb.n_dims() <= 8) ? sb.n_dims() : $urandom_range(1, 10);
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, len);
    for (int k = 0; k < len; k++) begin
      p = (sb.n_dims() <= 8) ? k[POS_W-1:0] : safe_pos(POS_W'($urandom));
      send(ACT_POINT, $urandom, int'(p), $urandom, k == len - 1);
    end
  endtask

  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4)
      send(ACT_LOAD, $urandom, $urandom, $urandom, coin());
    else if (pick < 7)
      send(ACT_READ, $urandom, $urandom, $urandom, coin());
    else if (pick == 7)
      send(ACT_CLEAR, $urandom, $urandom, $urandom, coin());
    else
      send(ACT_POINT, $urandom, int'(safe_pos(POS_W'($urandom))), $urandom, coin());
  endtask

  int phase_cl  [9] = '{16, 1, 0, 31, 5, 16, 7, 3, 16};
  int phase_dim [9] = '{8, 8, 1, 3, 0, 511, 256, 5, 8};
  int sent;

  initial begin
    sb = new();
    sb.clear_state();
    idling_on        = 1'b1;
    stall_left       = 0;
    quiet_cycles     = 0;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    items_if.valid   = 1'b0;
    items_if.action  = ACT_LOAD;
    items_if.cluster = '0;
    items_if.position     = '0;
    items_if.rank_value   = '0;
    items_if.last_element = 1'b0;
    results_if.ready = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_CLUSTERS, 16);
    write_reg(REG_DIMS, 8);

    // Load columns 0..7 and 255 of every centre, with both rank extremes present.
    for (int j = 0; j < N_CL; j++)
      for (int p = 0; p < 9; p++)
        send(ACT_LOAD, j, (p == 8) ? 255 : p,
             (j == 0 && p == 0) ? 0 : (j == 15 && p == 7) ? 4095 : $urandom, coin());

    // Directed: all-zero and all-max points, last mark beyond the active dims,
    // ties on an empty point, reads of both end clusters, clear.
    for (int p = 0; p < 8; p++) send(ACT_POINT, 0, p, 0, p == 7);
    for (int p = 0; p < 8; p++) send(ACT_POINT, 15, p, 4095, p == 7);
    send(ACT_POINT, 3, 200, 4095, 1);
    send(ACT_READ, 0, 0, 0, 0);
    send(ACT_READ, 15, 255, 4095, 1);
    send(ACT_CLEAR, 0, 0, 0, 0);
    send(ACT_READ, 0, 0, 0, 0);
    drain();

    // Saturate the running distance: one centre, one column hit repeatedly.
    write_reg(REG_CLUSTERS, 1);
    write_reg(REG_DIMS, 256);
    send(ACT_LOAD, 0, 255, 0, 0);
    for (int k = 0; k < 260; k++) send(ACT_POINT, 0, 255, 4095, k == 259);
    send(ACT_READ, 0, 0, 0, 0);
    drain();

    // Random phases over a sweep of register settings; the last one runs flat out.
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_CLUSTERS, phase_cl[ph]);
      write_reg(REG_DIMS, phase_dim[ph]);
      idling_on = (ph < 8);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) != 0) begin
          send_point();
          sent += (sb.n_dims() <= 8) ? sb.n_dims() : 5;
        end else begin
          send_noise();
          sent++;
        end
        if ($urandom_range(0, 15) == 0) send(ACT_READ, $urandom, $urandom, $urandom, coin());
      end
      for (int j = 0; j < N_CL; j++) send(ACT_READ, j, $urandom, $urandom, coin());
      drain();
    end

    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
